### rtl/bfd_pkg.sv
// shared types and constants for the broadcast frame deframer
package bfd_pkg;

	localparam logic [7:0] BCAST_TYPE = 8'd3;
	localparam logic [1:0] HDR_LAST_IDX = 2'd3;

	typedef enum logic [1:0] {
		KIND_AUTHOR = 2'd0,
		KIND_TEXT   = 2'd1,
		KIND_EMPTY  = 2'd2,
		KIND_BAD    = 2'd3
	} kind_t;

	typedef enum logic [5:0] {
		PH_TYPE = 6'b000001,
		PH_ALEN = 6'b000010,
		PH_TLEN = 6'b000100,
		PH_AUTH = 6'b001000,
		PH_TEXT = 6'b010000,
		PH_DEAD = 6'b100000
	} phase_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} res_t;

endpackage

### rtl/broadcast_frame_deframer.sv
// top level: byte stream in, tagged payload bytes out through a skid buffer
//
// in channel: in_valid / in_stall / in_byte, one stream byte per transaction.
// out channel: out_valid / out_stall / out_byte, out_kind, out_last.
// out_kind: author byte, text byte, empty-message marker, bad frame type.
// out_last marks the final result of a message.
// a transaction is taken at a rising edge with valid high and stall low.
// throughput: one byte per cycle while in_stall is low, set by the single
// parse stage updating the phase and the 32-bit length counters together.
// a result is registered in out_q, or in the skid register behind a stalled one.
// header bytes give no result, except the empty-message marker on the
// last length byte of a frame with both lengths zero.
// a wrong type byte gives one bad-type result, then all bytes are dropped.
// when the receiver stalls, one more result goes into the skid register,
// and in_stall rises while the skid register is full.
// reset clears the parser to wait for a type byte and empties both
// output registers.
module broadcast_frame_deframer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] out_kind,
	output logic       out_last
);

	bfd_pkg::res_t res;
	bfd_pkg::res_t out_q;
	bfd_pkg::res_t skid_q;
	logic          take;

	assign in_stall = skid_q.valid;
	assign take = in_valid && !in_stall;

	bfd_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.in_byte(in_byte),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
			skid_q <= '0;
		end else if (skid_q.valid) begin
			if (!out_stall) begin
				out_q <= skid_q;
				skid_q.valid <= 1'b0;
			end
		end else if (res.valid) begin
			if (out_q.valid && out_stall) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (!out_stall) begin
			out_q.valid <= 1'b0;
		end
	end

	assign out_valid = out_q.valid;
	assign out_byte = out_q.data;
	assign out_kind = out_q.kind;
	assign out_last = out_q.last;

endmodule

### rtl/bfd_parse.sv
// frame parser: phase, header index and the two length counters
module bfd_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          take,
	input  logic [7:0]    in_byte,
	output bfd_pkg::res_t res
);

	bfd_pkg::phase_t phase_q, phase_d;
	logic [1:0]      hidx_q, hidx_d;
	logic [31:0]     alen_q, alen_d;
	logic [31:0]     tlen_q, tlen_d;
	logic [31:0]     tlen_shift;

	assign tlen_shift = {tlen_q[23:0], in_byte};

	always_comb begin
		phase_d = phase_q;
		hidx_d = hidx_q;
		alen_d = alen_q;
		tlen_d = tlen_q;
		res.valid = 1'b0;
		res.data = 8'd0;
		res.kind = bfd_pkg::KIND_AUTHOR;
		res.last = 1'b0;
		unique case (phase_q)
			bfd_pkg::PH_TYPE: begin
				if (in_byte != bfd_pkg::BCAST_TYPE) begin
					phase_d = bfd_pkg::PH_DEAD;
					res.valid = 1'b1;
					res.kind = bfd_pkg::KIND_BAD;
				end else begin
					phase_d = bfd_pkg::PH_ALEN;
					hidx_d = 2'd0;
					alen_d = 32'd0;
					tlen_d = 32'd0;
				end
			end
			bfd_pkg::PH_ALEN: begin
				alen_d = {alen_q[23:0], in_byte};
				hidx_d = hidx_q + 2'd1;
				if (hidx_q == bfd_pkg::HDR_LAST_IDX) begin
					phase_d = bfd_pkg::PH_TLEN;
				end
			end
			bfd_pkg::PH_TLEN: begin
				tlen_d = tlen_shift;
				hidx_d = hidx_q + 2'd1;
				if (hidx_q == bfd_pkg::HDR_LAST_IDX) begin
					if (alen_q != 32'd0) begin
						phase_d = bfd_pkg::PH_AUTH;
					end else if (tlen_shift != 32'd0) begin
						phase_d = bfd_pkg::PH_TEXT;
					end else begin
						phase_d = bfd_pkg::PH_TYPE;
						res.valid = 1'b1;
						res.kind = bfd_pkg::KIND_EMPTY;
						res.last = 1'b1;
					end
				end
			end
			bfd_pkg::PH_AUTH: begin
				alen_d = alen_q - 32'd1;
				res.valid = 1'b1;
				res.data = in_byte;
				res.kind = bfd_pkg::KIND_AUTHOR;
				if (alen_q == 32'd1) begin
					if (tlen_q != 32'd0) begin
						phase_d = bfd_pkg::PH_TEXT;
					end else begin
						phase_d = bfd_pkg::PH_TYPE;
						res.last = 1'b1;
					end
				end
			end
			bfd_pkg::PH_TEXT: begin
				tlen_d = tlen_q - 32'd1;
				res.valid = 1'b1;
				res.data = in_byte;
				res.kind = bfd_pkg::KIND_TEXT;
				if (tlen_q == 32'd1) begin
					phase_d = bfd_pkg::PH_TYPE;
					res.last = 1'b1;
				end
			end
			bfd_pkg::PH_DEAD: begin
			end
			default: begin
				phase_d = bfd_pkg::PH_DEAD;
			end
		endcase
		if (!take) begin
			res.valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= bfd_pkg::PH_TYPE;
			hidx_q <= 2'd0;
			alen_q <= 32'd0;
			tlen_q <= 32'd0;
		end else if (take) begin
			phase_q <= phase_d;
			hidx_q <= hidx_d;
			alen_q <= alen_d;
			tlen_q <= tlen_d;
		end
	end

endmodule

### rtl/bfd_checker.sv
// port-level checks for the broadcast frame deframer, bound to the top level
module bfd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic [1:0] out_kind,
	input logic       out_last
);

	// skid register only fills behind a held result
	a_stall_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without a pending result");

	a_stall_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("in_stall rose without a stalled output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(out_kind)
			&& $stable(out_last))
		else $error("stalled result changed");

	a_markers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == bfd_pkg::KIND_EMPTY || out_kind == bfd_pkg::KIND_BAD)
			|-> out_byte == 8'd0 && (out_last == (out_kind == bfd_pkg::KIND_EMPTY)))
		else $error("marker result carries bad byte or last flag");

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte))
		else $error("stalled input transaction changed");

endmodule

bind broadcast_frame_deframer bfd_checker u_bfd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_byte  (in_byte),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_byte (out_byte),
	.out_kind (out_kind),
	.out_last (out_last)
);
